// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the timer manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ostm_pkg.sv -----
// Types and codes for the one-shot timer manager.
`timescale 1ns / 1ps
`default_nettype none

package ostm_pkg;

  localparam int ACTION_W = 2;
  localparam int AMOUNT_W = 20;
  localparam int HANDLE_W = 32;
  localparam int KIND_W   = 2;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [AMOUNT_W-1:0] amount_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [KIND_W-1:0]   kind_t;

  // Commands
  localparam action_t ACT_REGISTER = 2'd0;
  localparam action_t ACT_CANCEL   = 2'd1;
  localparam action_t ACT_EXTEND   = 2'd2;
  localparam action_t ACT_TICK     = 2'd3;

  // Result kinds
  localparam kind_t KIND_REGISTER = 2'd0;
  localparam kind_t KIND_EXTEND   = 2'd1;
  localparam kind_t KIND_EXPIRED  = 2'd2;

  // Expiries reported by one tick at most
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

// ----- rtl/core/one_shot_timer_manager.sv -----
// One-shot timer manager: slot memory, scan sequencer and result register.
//
//  Channel | Ports                                         | Handshake
//  --------+-----------------------------------------------+--------------------------
//  input   | in_action, in_amount_ms, in_timer_id          | beat taken on start & !busy
//  result  | out_result_kind, out_handle, out_ok, out_last | out_valid, one cycle each
//
// A register command never leaves idle; its reply beat follows in the next cycle.
// Cancel and extend scan the slot memory one entry per cycle.
// Tick runs one full pass over the slots per expired timer plus a final pass that finds none,
// or stops after MAX_RESULTS expiries; the single read port sets this.
// Reset (synchronous) clears the active bits, time and id counter at once; no clearing pass.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module one_shot_timer_manager #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire ostm_pkg::action_t  in_action,
  input  wire ostm_pkg::amount_t  in_amount_ms,
  input  wire ostm_pkg::handle_t  in_timer_id,
  output logic                    out_valid,
  output ostm_pkg::kind_t         out_result_kind,
  output ostm_pkg::handle_t       out_handle,
  output logic                    out_ok,
  output logic                    out_last
);

  import ostm_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = ((TIME_BITS > AMOUNT_W) ? TIME_BITS : AMOUNT_W) + 1;
  localparam int MW = TIME_BITS + HANDLE_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  // Saturating time add
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] base,
                                                   input amount_t inc);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(inc);
    if (|sum[SW-1:TIME_BITS]) return '1;
    return sum[TIME_BITS-1:0];
  endfunction

  // Control state
  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [SLOTS-1:0]     active_r, active_nxt;
  handle_t              seq_r, seq_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  cnt_t                 cnt_r, cnt_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic                 best_vld_r, best_vld_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Payload registers
  action_t              act_r;
  amount_t              amount_r;
  handle_t              id_r;
  logic [IW-1:0]        cmp_idx_r;
  logic [TIME_BITS-1:0] best_exp_r;
  handle_t              best_hdl_r;
  logic [IW-1:0]        best_idx_r;
  handle_t              pend_hdl_r;
  kind_t                out_kind_r, out_kind_nxt;
  handle_t              out_handle_r, out_handle_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic                 out_last_r, out_last_nxt;

  // Slot memory: expiry in the upper bits, handle in the lower
  logic [MW-1:0]        mem [SLOTS];
  logic [MW-1:0]        rd_data_r;
  logic                 mem_re;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [MW-1:0]        mem_wdata;

  logic                 accept;
  logic                 free_any;
  logic [IW-1:0]        free_idx;
  logic [TIME_BITS-1:0] rd_exp;
  handle_t              rd_hdl;
  logic                 cmp_act;
  logic                 hit;
  logic                 due;
  logic                 better;
  logic                 scan_done;
  logic                 best_ld;
  logic                 pend_ld;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Compare the entry read in the previous cycle
  assign rd_exp    = rd_data_r[MW-1:HANDLE_W];
  assign rd_hdl    = rd_data_r[HANDLE_W-1:0];
  assign cmp_act   = active_r[cmp_idx_r];
  assign hit       = cmp_vld_r && cmp_act && (rd_hdl == id_r);
  assign due       = cmp_vld_r && cmp_act && (rd_exp <= now_r);
  assign better    = !best_vld_r || (rd_exp < best_exp_r) ||
                     ((rd_exp == best_exp_r) && (rd_hdl < best_hdl_r));
  assign scan_done = cmp_vld_r && (cmp_idx_r == IW'(SLOTS - 1));
  assign best_ld   = (state_r == ST_SCAN) &&
                     ((act_r == ACT_TICK) ? (due && better) : (hit && !best_vld_r));
  assign pend_ld   = (state_r == ST_FIN) && (act_r == ACT_TICK) && best_vld_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    cmp_vld_nxt    = 1'b0;
    active_nxt     = active_r;
    seq_nxt        = seq_r;
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    pend_vld_nxt   = pend_vld_r;
    best_vld_nxt   = best_vld_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_handle_nxt = out_handle_r;
    out_ok_nxt     = out_ok_r;
    out_last_nxt   = out_last_r;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = free_idx;
    mem_wdata      = {sat_add(now_r, in_amount_ms), seq_r + 32'd1};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action) inside
            ACT_REGISTER: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_REGISTER;
              out_last_nxt  = 1'b1;
              if (free_any) begin
                seq_nxt              = seq_r + 32'd1;
                active_nxt[free_idx] = 1'b1;
                mem_we               = 1'b1;
                out_handle_nxt       = seq_r + 32'd1;
                out_ok_nxt           = 1'b1;
              end else begin
                out_handle_nxt = '0;
                out_ok_nxt     = 1'b0;
              end
            end
            ACT_CANCEL, ACT_EXTEND: begin
              state_nxt    = ST_SCAN;
              scan_nxt     = '0;
              best_vld_nxt = 1'b0;
            end
            ACT_TICK: begin
              now_nxt      = sat_add(now_r, in_amount_ms);
              state_nxt    = ST_SCAN;
              scan_nxt     = '0;
              best_vld_nxt = 1'b0;
              cnt_nxt      = '0;
              pend_vld_nxt = 1'b0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue the next read
        if (scan_r != CW'(SLOTS)) begin
          mem_re      = 1'b1;
          scan_nxt    = scan_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end
        if (act_r == ACT_TICK) begin
          if (due && better) best_vld_nxt = 1'b1;
          if (scan_done) state_nxt = ST_FIN;
        end else if (hit) begin
          best_vld_nxt = 1'b1;
          state_nxt    = ST_FIN;
        end else if (scan_done) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        case (act_r)
          ACT_CANCEL: begin
            if (best_vld_r) active_nxt[best_idx_r] = 1'b0;
            state_nxt = ST_IDLE;
          end
          ACT_EXTEND: begin
            mem_we         = best_vld_r;
            mem_waddr      = best_idx_r;
            mem_wdata      = {sat_add(best_exp_r, amount_r), id_r};
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_EXTEND;
            out_handle_nxt = id_r;
            out_ok_nxt     = best_vld_r;
            out_last_nxt   = 1'b1;
            state_nxt      = ST_IDLE;
          end
          default: begin
            // tick: release the earlier pending beat, hold the new one
            out_kind_nxt   = KIND_EXPIRED;
            out_handle_nxt = pend_hdl_r;
            out_ok_nxt     = 1'b1;
            out_valid_nxt  = pend_vld_r;
            if (best_vld_r) begin
              active_nxt[best_idx_r] = 1'b0;
              out_last_nxt           = 1'b0;
              pend_vld_nxt           = 1'b1;
              cnt_nxt                = cnt_r + 1'b1;
              if (cnt_r == CNT_W'(MAX_RESULTS - 1)) begin
                state_nxt = ST_FLUSH;
              end else begin
                state_nxt    = ST_SCAN;
                scan_nxt     = '0;
                best_vld_nxt = 1'b0;
              end
            end else begin
              out_last_nxt = 1'b1;
              pend_vld_nxt = 1'b0;
              state_nxt    = ST_IDLE;
            end
          end
        endcase
      end

      ST_FLUSH: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_EXPIRED;
        out_handle_nxt = pend_hdl_r;
        out_ok_nxt     = 1'b1;
        out_last_nxt   = 1'b1;
        pend_vld_nxt   = 1'b0;
        state_nxt      = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_r      <= '0;
      cmp_vld_r   <= 1'b0;
      active_r    <= '0;
      seq_r       <= '0;
      now_r       <= '0;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      active_r    <= active_nxt;
      seq_r       <= seq_nxt;
      now_r       <= now_nxt;
      cnt_r       <= cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_action;
      amount_r <= in_amount_ms;
      id_r     <= in_timer_id;
    end
    if (mem_re) cmp_idx_r <= scan_r[IW-1:0];
    if (best_ld) begin
      best_exp_r <= rd_exp;
      best_hdl_r <= rd_hdl;
      best_idx_r <= cmp_idx_r;
    end
    if (pend_ld) pend_hdl_r <= best_hdl_r;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_ok_r     <= out_ok_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[scan_r[IW-1:0]];
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_handle      = out_handle_r;
  assign out_ok          = out_ok_r;
  assign out_last        = out_last_r;

  // Checks
  `ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == ST_SCAN, scan_r <= CW'(SLOTS), "scan overrun")
  `ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_RESULTS), "tick count overrun")
  `ASSERT_IMP(a_flush_pend, clk, rst_n, state_r == ST_FLUSH, pend_vld_r, "flush without beat")
  `ASSERT_IMP(a_exp_src, clk, rst_n,
              out_valid && (out_result_kind == KIND_EXPIRED),
              ($past(state_r) == ST_FIN) || ($past(state_r) == ST_FLUSH),
              "stray expiry beat")
  `ASSERT_NEXT(a_full_reply, clk, rst_n,
               accept && (in_action == ACT_REGISTER) && !free_any,
               out_valid && !out_ok,
               "full reply missing")

endmodule

`default_nettype wire

// ----- tb/ostm_checker.sv -----
// Timer manager checker: watches both channels, predicts the replies and compares them.
`timescale 1ns / 1ps

module ostm_checker #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire                busy,
  input  ostm_pkg::action_t  in_action,
  input  ostm_pkg::amount_t  in_amount_ms,
  input  ostm_pkg::handle_t  in_timer_id,
  input  wire                out_valid,
  input  ostm_pkg::kind_t    out_result_kind,
  input  ostm_pkg::handle_t  out_handle,
  input  wire                out_ok,
  input  wire                out_last,
  output int unsigned        fail_count,
  output int unsigned        pending
);
  import ostm_pkg::*;

  typedef logic [TIME_BITS-1:0] stamp_t;

  typedef struct packed {
    kind_t   kind;
    handle_t handle;
    logic    ok;
    logic    last;
  } reply_t;

  // Shadow of the slot memory, the id counter and the millisecond clock
  stamp_t  due_at [SLOTS];
  handle_t owner  [SLOTS];
  logic    armed  [SLOTS];
  handle_t next_id;
  stamp_t  now_ms;

  reply_t      awaited [$];
  reply_t      want;
  int unsigned errors;

  initial begin
    fail_count = 0;
    pending    = 0;
    errors     = 0;
  end

  // Clamp at the all-ones time value rather than wrap
  function automatic stamp_t add_clamped(stamp_t base, amount_t inc);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, base} + inc;
    return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  endfunction

  // Lowest-index armed slot holding this id, or -1
  function automatic int find_armed(handle_t id);
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (armed[i] && owner[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic reply_t make_reply(kind_t kind, handle_t h, logic ok, logic last);
    reply_t r;
    r.kind   = kind;
    r.handle = h;
    r.ok     = ok;
    r.last   = last;
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    errors++;
    $display("%0t ns: MISMATCH %s", $time, what);
  endtask

  // Update the shadow state for one command and queue the replies it causes
  task automatic predict_replies(action_t act, amount_t amt, handle_t id);
    int     i;
    int     slot;
    int     best;
    int     n;
    reply_t held;
    logic   have_held;
    slot      = -1;
    n         = 0;
    have_held = 1'b0;
    held      = '0;
    case (act)
      ACT_REGISTER: begin
        for (i = SLOTS - 1; i >= 0; i--) begin
          if (!armed[i]) slot = i;
        end
        if (slot < 0) begin
          awaited.push_back(make_reply(KIND_REGISTER, '0, 1'b0, 1'b1));
        end else begin
          next_id      = next_id + 1'b1;
          armed[slot]  = 1'b1;
          owner[slot]  = next_id;
          due_at[slot] = add_clamped(now_ms, amt);
          awaited.push_back(make_reply(KIND_REGISTER, next_id, 1'b1, 1'b1));
        end
      end
      ACT_CANCEL: begin
        slot = find_armed(id);
        if (slot >= 0) armed[slot] = 1'b0;
      end
      ACT_EXTEND: begin
        slot = find_armed(id);
        if (slot >= 0) due_at[slot] = add_clamped(due_at[slot], amt);
        awaited.push_back(make_reply(KIND_EXTEND, id, slot >= 0, 1'b1));
      end
      default: begin
        now_ms = add_clamped(now_ms, amt);
        // Pop expired timers earliest first, ties by lower id then lower slot
        while (n < MAX_RESULTS) begin
          best = -1;
          for (i = 0; i < SLOTS; i++) begin
            if (armed[i] && due_at[i] <= now_ms) begin
              if (best < 0) best = i;
              else if (due_at[i] < due_at[best]) best = i;
              else if (due_at[i] == due_at[best] && owner[i] < owner[best]) best = i;
            end
          end
          if (best < 0) break;
          armed[best] = 1'b0;
          if (have_held) awaited.push_back(held);
          held      = make_reply(KIND_EXPIRED, owner[best], 1'b1, 1'b0);
          have_held = 1'b1;
          n++;
        end
        // Mark the final expiry of this tick
        if (have_held) begin
          held.last = 1'b1;
          awaited.push_back(held);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) armed[i] = 1'b0;
      next_id = '0;
      now_ms  = '0;
      awaited.delete();
    end else begin
      // Compare a result beat with the oldest expectation first
      if (out_valid === 1'b1) begin
        if (awaited.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat kind %0d handle %h", out_result_kind,
                                  out_handle));
        end else begin
          want = awaited.pop_front();
          if (out_result_kind !== want.kind)
            flag_mismatch($sformatf("kind got %0d want %0d (handle %h)", out_result_kind,
                                    want.kind, want.handle));
          if (out_handle !== want.handle)
            flag_mismatch($sformatf("handle got %h want %h", out_handle, want.handle));
          if (out_ok !== want.ok)
            flag_mismatch($sformatf("ok got %b want %b (handle %h)", out_ok, want.ok,
                                    want.handle));
          if (out_last !== want.last)
            flag_mismatch($sformatf("last got %b want %b (handle %h)", out_last, want.last,
                                    want.handle));
        end
      end
      // Then take a command beat into the shadow model
      if (start === 1'b1 && busy === 1'b0)
        predict_replies(in_action, in_amount_ms, in_timer_id);
    end
    fail_count <= errors;
    pending    <= awaited.size();
  end

endmodule

// ----- tb/tb.sv -----
// Timer manager testbench top: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import ostm_pkg::*;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 48;
  localparam int RANDOM_CMDS = 435;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  action_t in_action = ACT_TICK;
  amount_t in_amount_ms = '0;
  handle_t in_timer_id = '0;

  wire     busy;
  wire     out_valid;
  kind_t   out_result_kind;
  handle_t out_handle;
  wire     out_ok;
  wire     out_last;

  int unsigned fail_count;
  int unsigned pending;

  handle_t latest_id = '0;
  logic    steady = 1'b0;

  one_shot_timer_manager #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_amount_ms    (in_amount_ms),
    .in_timer_id     (in_timer_id),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_handle      (out_handle),
    .out_ok          (out_ok),
    .out_last        (out_last)
  );

  ostm_checker #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_amount_ms    (in_amount_ms),
    .in_timer_id     (in_timer_id),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_handle      (out_handle),
    .out_ok          (out_ok),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold the newest granted id so cancel and extend mostly hit live timers
  always @(posedge clk) begin
    if (out_valid && out_result_kind == KIND_REGISTER && out_ok) latest_id <= out_handle;
  end

  // Present one command beat and hold it until the block takes it
  task automatic issue(action_t act, amount_t amt, handle_t id);
    while (!steady && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_action    <= act;
    in_amount_ms <= amt;
    in_timer_id  <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Pick a handle near the newest id, or pure noise now and then
  function automatic handle_t pick_id();
    if ($urandom_range(0, 99) < 15) return $urandom;
    return latest_id - handle_t'($urandom_range(0, 17));
  endfunction

  function automatic amount_t pick_delay();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return amount_t'($urandom_range(0, 60));
    if (roll < 90) return amount_t'($urandom_range(0, 2000));
    return amount_t'($urandom_range(0, 20'hFFFFF));
  endfunction

  function automatic amount_t pick_elapsed();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 90) return amount_t'($urandom_range(0, 40));
    return amount_t'($urandom_range(0, 20'hFFFFF));
  endfunction

  initial begin
    int unsigned roll;
    int unsigned w;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, unknown cancel and extend, extremes of delay
    issue(ACT_TICK, '0, 32'hFFFF_FFFF);
    issue(ACT_CANCEL, 20'hFFFFF, 32'hFFFF_FFFF);
    issue(ACT_EXTEND, 20'h00001, '0);
    issue(ACT_REGISTER, '0, '0);
    issue(ACT_REGISTER, 20'hFFFFF, 32'hFFFF_FFFF);
    // Fill the remaining slots with tied expiries, then one register too many
    for (int i = 0; i < SLOTS - 2; i++) issue(ACT_REGISTER, 20'd10, handle_t'(i));
    issue(ACT_REGISTER, 20'd5, '0);
    // Extend the far timer by the largest amount, nudge one tied timer, cancel another
    issue(ACT_EXTEND, 20'hFFFFF, 32'd2);
    issue(ACT_EXTEND, 20'd3, 32'd5);
    issue(ACT_CANCEL, '0, 32'd7);
    // Mass expiry with ties ordered by id, then the stragglers
    issue(ACT_TICK, 20'd10, '0);
    issue(ACT_TICK, 20'hFFFFF, '0);
    issue(ACT_TICK, 20'hFFFFF, 32'hFFFF_FFFF);

    // Random commands; a long middle stretch runs with no idling
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      steady <= (n >= 150 && n < 300);
      roll = $urandom_range(0, 99);
      if (roll < 38) issue(ACT_REGISTER, pick_delay(), $urandom);
      else if (roll < 50) issue(ACT_CANCEL, amount_t'($urandom), pick_id());
      else if (roll < 68) begin
        if ($urandom_range(0, 9) == 0) issue(ACT_EXTEND, amount_t'($urandom), pick_id());
        else issue(ACT_EXTEND, amount_t'($urandom_range(0, 100)), pick_id());
      end else issue(ACT_TICK, pick_elapsed(), $urandom);
    end
    start <= 1'b0;

    // Drain the outstanding replies, then let a trailing scan settle
    w = 0;
    while (pending != 0 && w < 20000) begin
      @(posedge clk);
      w++;
    end
    repeat (400) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("one_shot_timer_manager verification clean");
    end else begin
      $display("one_shot_timer_manager verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("one_shot_timer_manager verification failed");
    $finish;
  end

endmodule
